/* hdl/psa_pkg.sv */
// Package for the period statistics accumulator: operation codes, kind codes and state encoding.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none
package psa_pkg;
   localparam logic [3:0] FUNC_ADD         = 4'd0;
   localparam logic [3:0] FUNC_PERIOD_SUM  = 4'd1;
   localparam logic [3:0] FUNC_PERIOD_RMS  = 4'd2;
   localparam logic [3:0] FUNC_PERIOD_MEAN = 4'd3;
   localparam logic [3:0] FUNC_PERIOD_RAT  = 4'd4;
   localparam logic [3:0] FUNC_TOTAL_SUM   = 4'd5;
   localparam logic [3:0] FUNC_TOTAL_RMS   = 4'd6;
   localparam logic [3:0] FUNC_TOTAL_MEAN  = 4'd7;
   localparam logic [3:0] FUNC_TOTAL_RAT   = 4'd8;

   typedef enum logic [1:0] {
      KIND_SUM   = 2'd0,
      KIND_RMS   = 2'd1,
      KIND_MEAN  = 2'd2,
      KIND_RATIO = 2'd3
   } kind_type;

   typedef enum logic [4:0] {
      ST_IDLE = 5'b00001,
      ST_DIV  = 5'b00010,
      ST_SQRT = 5'b00100,
      ST_FIX  = 5'b01000,
      ST_OUT  = 5'b10000
   } state_type;
endpackage
`default_nettype wire

/* hdl/psa_divsqrt.sv */
// Shared restoring divider / bit-serial square root unit, one bit per cycle.
// Depends on psa_pkg (kind codes).
`timescale 1ns / 1ps
`default_nettype none
module psa_divsqrt #(
   parameter int FRAC_BITS   = 16,
   parameter int RATIO_SCALE = 10000
) (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               start,
   input  wire psa_pkg::kind_type  kind,
   input  wire logic signed [63:0] s_in,
   input  wire logic [31:0]        n_in,
   input  wire logic signed [63:0] d_in,
   output logic                    done,
   output logic signed [63:0]      res
);
   localparam logic [127:0] SCALE = 128'(RATIO_SCALE) << FRAC_BITS;

   // phase: 0 idle, 1 dividing, 2 square root, 3 finishing the quotient
   logic [1:0]   phase_ff, phase_in;
   logic [6:0]   cnt_ff, cnt_in;
   logic [127:0] num_ff, num_in;
   logic [63:0]  dm_ff, dm_in;
   logic [64:0]  rem_ff, rem_in;
   logic [127:0] quo_ff, quo_in;
   logic         neg_ff, neg_in;
   logic         zero_ff, zero_in;
   logic         done_ff, done_in;
   logic signed [63:0] res_ff, res_in;
   psa_pkg::kind_type kind_ff, kind_in;
   // square root regs
   logic [95:0]  sq_rad_ff, sq_rad_in;
   logic [97:0]  sq_rem_ff, sq_rem_in;
   logic [47:0]  sq_root_ff, sq_root_in;

   logic [63:0]  s_mag;
   logic [127:0] prod;
   logic [64:0]  trial;
   logic [97:0]  sq_trial, sq_sub;
   logic [63:0]  q_s;

   assign s_mag = s_in[63] ? 64'(-s_in) : 64'(s_in);
   assign prod  = {64'd0, s_mag} * SCALE;
   assign trial = {rem_ff[63:0], num_ff[127]};
   assign sq_trial = {sq_rem_ff[95:0], sq_rad_ff[95:94]};
   assign sq_sub   = {48'd0, sq_root_ff, 2'b01};
   assign q_s = neg_ff ? 64'(-quo_ff[63:0]) : quo_ff[63:0];

   always_comb begin
      phase_in = phase_ff; cnt_in = cnt_ff; num_in = num_ff; dm_in = dm_ff;
      rem_in = rem_ff; quo_in = quo_ff; neg_in = neg_ff; zero_in = zero_ff;
      done_in = 1'b0; res_in = res_ff; kind_in = kind_ff;
      sq_rad_in = sq_rad_ff; sq_rem_in = sq_rem_ff; sq_root_in = sq_root_ff;
      unique case (phase_ff)
         2'd0: begin
            if (start) begin
               kind_in = kind;
               rem_in  = '0;
               quo_in  = '0;
               if (kind == psa_pkg::KIND_RATIO) begin
                  num_in  = prod;
                  dm_in   = d_in[63] ? 64'(-d_in) : 64'(d_in);
                  neg_in  = s_in[63] != d_in[63];
                  zero_in = (d_in == 0) || (s_in == 0);
               end else begin
                  num_in  = {s_mag, 64'd0};
                  dm_in   = {32'd0, n_in};
                  neg_in  = s_in[63];
                  zero_in = (n_in == 0);
               end
               cnt_in   = (kind == psa_pkg::KIND_RATIO) ? 7'd127 : 7'd63;
               phase_in = 2'd1;
            end
         end
         2'd1: begin
            // restoring divide step: shift in one numerator bit
            num_in = num_ff << 1;
            if (trial >= {1'b0, dm_ff}) begin
               rem_in = trial - {1'b0, dm_ff};
               quo_in = {quo_ff[126:0], 1'b1};
            end else begin
               rem_in = trial;
               quo_in = {quo_ff[126:0], 1'b0};
            end
            cnt_in = cnt_ff - 7'd1;
            if (cnt_ff == 7'd0) phase_in = 2'd3;
         end
         2'd2: begin
            sq_rad_in = sq_rad_ff << 2;
            if (sq_trial >= sq_sub) begin
               sq_rem_in  = sq_trial - sq_sub;
               sq_root_in = {sq_root_ff[46:0], 1'b1};
            end else begin
               sq_rem_in  = sq_trial;
               sq_root_in = {sq_root_ff[46:0], 1'b0};
            end
            cnt_in = cnt_ff - 7'd1;
            if (cnt_ff == 7'd0) begin
               phase_in = 2'd0;
               done_in  = 1'b1;
               res_in   = 64'(sq_root_in);
            end
         end
         default: begin
            // finish the quotient
            phase_in = 2'd0;
            done_in  = 1'b1;
            if (kind_ff == psa_pkg::KIND_RATIO) begin
               if (zero_ff) res_in = '0;
               else if (!neg_ff)
                  res_in = (quo_ff[127:64] != 0 || quo_ff[63]) ?
                           64'h7FFF_FFFF_FFFF_FFFF : quo_ff[63:0];
               else
                  res_in = (quo_ff[127:64] != 0 || quo_ff[63:0] > 64'h8000_0000_0000_0000) ?
                           64'h8000_0000_0000_0000 : 64'(-quo_ff[63:0]);
            end else if (zero_ff) begin
               res_in = '0;
            end else if (kind_ff == psa_pkg::KIND_MEAN) begin
               res_in = q_s;
            end else begin
               if (q_s[63] || q_s == 0) res_in = '0;
               else begin
                  done_in    = 1'b0;
                  phase_in   = 2'd2;
                  sq_rad_in  = {32'(q_s >> (64 - FRAC_BITS)), 64'(q_s << FRAC_BITS)};
                  sq_rem_in  = '0;
                  sq_root_in = '0;
                  cnt_in     = 7'd47;
               end
            end
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= 2'd0;
         done_ff  <= 1'b0;
      end else begin
         phase_ff <= phase_in;
         done_ff  <= done_in;
      end
      cnt_ff <= cnt_in; num_ff <= num_in; dm_ff <= dm_in; rem_ff <= rem_in;
      quo_ff <= quo_in; neg_ff <= neg_in; zero_ff <= zero_in; res_ff <= res_in;
      kind_ff <= kind_in; sq_rad_ff <= sq_rad_in; sq_rem_ff <= sq_rem_in;
      sq_root_ff <= sq_root_in;
   end

   assign done = done_ff;
   assign res  = res_ff;
endmodule
`default_nettype wire

/* hdl/period_statistics_accumulator_unit.sv */
// Period statistics accumulator: period and grand totals with sum/RMS/mean/ratio.
// Add and sum-close requests are answered without the arithmetic unit; mean, ratio and rms
// results come from the one-bit-per-cycle shared divide/square-root unit (psa_divsqrt).
// Throughput: one word at a time; req_tready is low while an item is in work.
// Reset: synchronous, active high; clears all accumulators and the handshake.
// Depends on psa_pkg and psa_divsqrt.
`timescale 1ns / 1ps
`default_nettype none
module period_statistics_accumulator_unit #(
   parameter int FRAC_BITS   = 16,
   parameter int RATIO_SCALE = 10000
) (
   input  wire logic         clock,
   input  wire logic         reset,
   input  wire logic         req_tvalid,
   output logic              req_tready,
   input  wire logic [71:0]  req_tdata,  // func[3:0], value[35:4], side_value[67:36]
   output logic              rsp_tvalid,
   input  wire logic         rsp_tready,
   output logic [159:0]      rsp_tdata   // result[63:0], total_items[95:64], total_side_sum[159:96]
);
   localparam logic signed [63:0] SMAX = 64'sh7FFF_FFFF_FFFF_FFFF;
   localparam logic signed [63:0] SMIN = 64'sh8000_0000_0000_0000;

   psa_pkg::state_type state_ff, state_in;
   logic [31:0]        pcnt_ff, pcnt_in, gcnt_ff, gcnt_in;
   logic signed [63:0] psum_ff, psum_in, pside_ff, pside_in;
   logic signed [63:0] gsum_ff, gsum_in, gside_ff, gside_in;
   logic signed [63:0] res_ff, res_in;
   logic               start;
   psa_pkg::kind_type  kind;
   logic signed [63:0] op_s, op_d;
   logic [31:0]        op_n;
   logic               du_done;
   logic signed [63:0] du_res;

   logic [3:0]         func;
   logic signed [31:0] value, side_value;
   assign func       = req_tdata[3:0];
   assign value      = req_tdata[35:4];
   assign side_value = req_tdata[67:36];

   function automatic logic signed [63:0] sat_add(logic signed [63:0] a, logic signed [63:0] b);
      logic signed [63:0] s;
      s = a + b;
      if (!a[63] && !b[63] && s[63]) return SMAX;
      if (a[63] && b[63] && !s[63]) return SMIN;
      return s;
   endfunction

   function automatic logic [31:0] sat_inc(logic [31:0] a, logic [31:0] b);
      logic [32:0] s;
      s = {1'b0, a} + {1'b0, b};
      return s[32] ? 32'hFFFF_FFFF : s[31:0];
   endfunction

   wire accept = req_tvalid && req_tready;
   wire is_period = (func >= psa_pkg::FUNC_PERIOD_SUM) && (func <= psa_pkg::FUNC_PERIOD_RAT);
   wire is_total  = (func >= psa_pkg::FUNC_TOTAL_SUM) && (func <= psa_pkg::FUNC_TOTAL_RAT);

   // pick the operands: period or grand totals
   assign op_s = is_period ? psum_ff : gsum_ff;
   assign op_n = is_period ? pcnt_ff : gcnt_ff;
   assign op_d = is_period ? pside_ff : gside_ff;
   assign kind = psa_pkg::kind_type'(is_period ? 2'(func - psa_pkg::FUNC_PERIOD_SUM)
                                               : 2'(func - psa_pkg::FUNC_TOTAL_SUM));
   // sums need no arithmetic unit
   assign start = accept && (is_period || is_total) && (kind != psa_pkg::KIND_SUM);

   psa_divsqrt #(.FRAC_BITS(FRAC_BITS), .RATIO_SCALE(RATIO_SCALE)) u_du (
      .clock(clock), .reset(reset), .start(start), .kind(kind),
      .s_in(op_s), .n_in(op_n), .d_in(op_d), .done(du_done), .res(du_res)
   );

   always_comb begin
      state_in = state_ff;
      pcnt_in = pcnt_ff; psum_in = psum_ff; pside_in = pside_ff;
      gcnt_in = gcnt_ff; gsum_in = gsum_ff; gside_in = gside_ff;
      res_in = res_ff;
      unique case (state_ff)
         psa_pkg::ST_IDLE: begin
            if (accept) begin
               res_in = '0;
               if (func == psa_pkg::FUNC_ADD) begin
                  pcnt_in  = sat_inc(pcnt_ff, 32'd1);
                  psum_in  = sat_add(psum_ff, 64'(value));
                  pside_in = sat_add(pside_ff, 64'(side_value));
               end else if (is_period) begin
                  // fold the period into the totals, then clear it
                  gcnt_in  = sat_inc(gcnt_ff, pcnt_ff);
                  gsum_in  = sat_add(gsum_ff, psum_ff);
                  gside_in = sat_add(gside_ff, pside_ff);
                  pcnt_in = '0; psum_in = '0; pside_in = '0;
                  res_in = psum_ff;
               end else if (is_total) begin
                  pcnt_in = '0; psum_in = '0; pside_in = '0;
                  gcnt_in = '0; gsum_in = '0; gside_in = '0;
                  res_in = gsum_ff;
               end
               state_in = start ? psa_pkg::ST_DIV : psa_pkg::ST_OUT;
            end
         end
         psa_pkg::ST_DIV: begin
            // hold until the shared unit finishes
            if (du_done) begin
               res_in   = du_res;
               state_in = psa_pkg::ST_OUT;
            end
         end
         psa_pkg::ST_OUT: begin
            if (rsp_tready) state_in = psa_pkg::ST_IDLE;
         end
         default: state_in = psa_pkg::ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= psa_pkg::ST_IDLE;
         pcnt_ff <= '0; psum_ff <= '0; pside_ff <= '0;
         gcnt_ff <= '0; gsum_ff <= '0; gside_ff <= '0;
      end else begin
         state_ff <= state_in;
         pcnt_ff <= pcnt_in; psum_ff <= psum_in; pside_ff <= pside_in;
         gcnt_ff <= gcnt_in; gsum_ff <= gsum_in; gside_ff <= gside_in;
      end
      res_ff <= res_in;
   end

   assign req_tready = (state_ff == psa_pkg::ST_IDLE);
   assign rsp_tvalid = (state_ff == psa_pkg::ST_OUT);
   assign rsp_tdata  = {gside_ff, gcnt_ff, res_ff};

`ifndef ASSERT_OFF
   a_no_accept_busy: assert property (@(posedge clock) disable iff (reset)
      (state_ff != psa_pkg::ST_IDLE) |-> !req_tready) else $error("ready while busy");
   a_done_in_div: assert property (@(posedge clock) disable iff (reset)
      du_done |-> (state_ff == psa_pkg::ST_DIV)) else $error("unit done outside divide");
   a_out_after: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && !rsp_tready) |=> rsp_tvalid) else $error("result dropped");
`endif
endmodule
`default_nettype wire
